// ===== rtl/crc16_pkg.sv =====
// Shared types, constants and the byte-wide CRC-16 update for the packet checker.
// Used by crc16_core and crc16_ccitt_packet_checker; depends on nothing else.
package crc16_pkg;

   // Generator polynomial, MSB-first, and register reset values.
   localparam logic [15:0] CrcPoly        = 16'h1021;
   localparam logic [15:0] CrcInitDefault = 16'h1D0F;
   localparam logic [15:0] CrcXorDefault  = 16'h0000;

   // Configuration register indexes.
   localparam int CsrIndexWidth = 1;
   localparam logic [CsrIndexWidth-1:0] CsrInitialRemainder = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CsrFinalXor         = 1'b1;

   // Control passed from the pipeline to the CRC datapath for one byte.
   typedef struct packed {
      logic fire;   // the byte in the input stage is folded this cycle
      logic last;   // that byte closes the packet
   } step_ctrl_type;

   // Folds one byte into the remainder, most significant bit first.
   // Eight shift/xor steps on a 16-bit value; this is the table-free form.
   function automatic logic [15:0] fold_byte(input logic [15:0] rem, input logic [7:0] b);
      logic [15:0] r;
      r = rem ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (r[15]) begin
            r = {r[14:0], 1'b0} ^ CrcPoly;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/crc16_core.sv =====
// CRC datapath: running remainder register and the per-byte fold.
// Depends on crc16_pkg for the fold function, control struct and reset value.
module crc16_core (
   input  logic                     clock,
   input  logic                     reset,
   input  crc16_pkg::step_ctrl_type ctrl,
   input  logic [7:0]               data_byte,
   input  logic [15:0]              reload_value,
   input  logic [15:0]              final_xor,
   output logic [15:0]              final_crc
);
   import crc16_pkg::*;

   logic [15:0] running_ff;
   logic [15:0] running_in;
   logic [15:0] folded;

   // Fold the staged byte into the running remainder.
   assign folded    = fold_byte(running_ff, data_byte);
   assign final_crc = folded ^ final_xor;

   // A closing byte reloads the remainder for the next packet.
   always_comb begin
      running_in = running_ff;
      if (ctrl.fire) begin
         running_in = ctrl.last ? reload_value : folded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= CrcInitDefault;
      end else begin
         running_ff <= running_in;
      end
   end

endmodule

// ===== rtl/crc16_ccitt_packet_checker.sv =====
// Top level of the CRC-16 (AUG-CCITT style) packet checker.
// Depends on crc16_pkg and crc16_core.
//
// Usage:
//   Bytes arrive on the req_ channel (req_data_byte, req_last_byte) with a
//   valid/ready handshake, one transaction per byte. The byte marked last
//   closes the packet and produces one transaction on the rsp_ channel:
//   rsp_checksum_swapped holds the final CRC (remainder xor final_xor) with
//   its two bytes swapped, and rsp_residue_zero is high when the final CRC
//   is zero, which verifies a packet that carries its own checksum.
//   Bytes without the last mark produce no response.
//   A byte is registered in an input stage and folded from there; folding
//   the closing byte registers the result on rsp_. Throughput is one byte
//   per cycle unless a closing byte waits on a stalled result, limited only
//   by the byte fold between the input stage and the result register.
//   When the receiver stalls, the result register holds; bytes without the
//   last mark keep flowing, and a second closing byte waits in the input
//   stage, which then deasserts req_ready.
//   Reset (synchronous, active high) empties both stages and sets the
//   initial remainder to 0x1D0F and the final xor to 0x0000.
//   CSR writes (csr_write_enable, csr_index, csr_write_data) take effect at
//   once; a new initial remainder takes over at the next closing byte.
module crc16_ccitt_packet_checker (
   input  logic                                clock,
   input  logic                                reset,
   // Byte channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_last_byte,
   // Result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [15:0]                         rsp_checksum_swapped,
   output logic                                rsp_residue_zero,
   // Configuration write port
   input  logic                                csr_write_enable,
   input  logic [crc16_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [15:0]                         csr_write_data
);
   import crc16_pkg::*;

   logic [15:0]   init_ff, init_in;
   logic [15:0]   xor_ff, xor_in;
   logic          s1_valid_ff, s1_valid_in;
   logic [7:0]    s1_data_ff, s1_data_in;
   logic          s1_last_ff, s1_last_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_swap_ff, rsp_swap_in;
   logic          rsp_zero_ff, rsp_zero_in;
   logic          out_free;
   logic          s1_fire;
   logic [15:0]   final_crc;
   step_ctrl_type step_ctrl;

   // Configuration registers.
   always_comb begin
      init_in = init_ff;
      xor_in  = xor_ff;
      if (csr_write_enable) begin
         if (csr_index == CsrInitialRemainder) begin
            init_in = csr_write_data;
         end else if (csr_index == CsrFinalXor) begin
            xor_in = csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= CrcInitDefault;
         xor_ff  <= CrcXorDefault;
      end else begin
         init_ff <= init_in;
         xor_ff  <= xor_in;
      end
   end

   // Pipeline control: a staged byte moves on unless it closes a packet
   // while the result register still holds an untaken result.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_ready = !s1_valid_ff || s1_fire;

   assign step_ctrl.fire = s1_fire;
   assign step_ctrl.last = s1_last_ff;

   // Input stage.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      s1_last_in  = s1_last_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
         s1_data_in  = req_data_byte;
         s1_last_in  = req_last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
      s1_last_ff <= s1_last_in;
   end

   crc16_core u_core (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (step_ctrl),
      .data_byte    (s1_data_ff),
      .reload_value (init_ff),
      .final_xor    (xor_ff),
      .final_crc    (final_crc)
   );

   // Result register: loaded when a closing byte is folded.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_swap_in  = rsp_swap_ff;
      rsp_zero_in  = rsp_zero_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_fire && s1_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_swap_in  = {final_crc[7:0], final_crc[15:8]};
         rsp_zero_in  = (final_crc == 16'h0000);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_swap_ff <= rsp_swap_in;
      rsp_zero_ff <= rsp_zero_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_checksum_swapped = rsp_swap_ff;
   assign rsp_residue_zero     = rsp_zero_ff;

`ifndef NO_ASSERTIONS
   // The zero flag agrees with the checksum it travels with.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_zero_ff == (rsp_swap_ff == 16'h0000)))
      else $error("residue flag does not match checksum");

   // A new result only ever follows a closing byte in the input stage.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_last_ff))
      else $error("result produced without a closing byte");

   // Folding a closing byte always leaves a result pending.
   assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_last_ff) |=> rsp_valid_ff)
      else $error("closing byte folded but no result registered");

   // Back-pressure reaches the byte channel only from a stalled result.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid_ff && !rsp_ready && s1_valid_ff && s1_last_ff))
      else $error("byte channel stalled without a stalled result");
`endif

endmodule

// ===== sim/crc16_ccitt_packet_checker_test.sv =====
// Self-checking testbench for crc16_ccitt_packet_checker: sends packets byte by byte,
// predicts the swapped CRC and zero-residue flag of each packet, and checks every result.
// Depends on crc16_pkg and the RTL of crc16_ccitt_packet_checker.
`timescale 1ns / 100ps

module crc16_ccitt_packet_checker_test;
   import crc16_pkg::*;

   // One expected result transaction.
   typedef struct {
      logic [15:0] checksum_swapped;
      logic        residue_zero;
   } crc_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [7:0]               req_data_byte = 8'h00;
   logic                     req_last_byte = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [15:0]              rsp_checksum_swapped;
   logic                     rsp_residue_zero;
   logic                     csr_write_enable = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = CsrInitialRemainder;
   logic [15:0]              csr_write_data = 16'h0000;

   // Predictor state: register copies and the running remainder.
   logic [15:0]    cfg_reload_value = CrcInitDefault;
   logic [15:0]    cfg_final_xor = CrcXorDefault;
   logic [15:0]    crc_running = CrcInitDefault;
   crc_result_type expected_results[$];

   int error_count = 0;
   bit sender_idle_on = 1'b1;
   bit receiver_idle_on = 1'b1;
   int rsp_hold_cycles = 0;
   bit rsp_hold_active = 1'b0;

   crc16_ccitt_packet_checker dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_last_byte        (req_last_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_checksum_swapped (rsp_checksum_swapped),
      .rsp_residue_zero     (rsp_residue_zero),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   // 2 ns clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shifts one byte into the remainder a bit at a time, MSB first, as a serial LFSR would.
   function automatic logic [15:0] crc_fold_byte(input logic [15:0] rem, input logic [7:0] b);
      logic [15:0] r;
      logic        feedback;
      r = rem;
      for (int i = 7; i >= 0; i--) begin
         feedback = r[15] ^ b[i];
         r = {r[14:0], 1'b0};
         if (feedback) begin
            r = r ^ CrcPoly;
         end
      end
      return r;
   endfunction

   // Updates the predictor for one accepted byte; a closing byte queues its result
   // and restarts the remainder from the initial remainder register.
   task automatic fold_accepted_byte(input logic [7:0] data, input logic last);
      crc_result_type result;
      logic [15:0]    final_crc;
      crc_running = crc_fold_byte(crc_running, data);
      if (last) begin
         final_crc = crc_running ^ cfg_final_xor;
         result.checksum_swapped = {final_crc[7:0], final_crc[15:8]};
         result.residue_zero = (final_crc == 16'h0000);
         expected_results.push_back(result);
         crc_running = cfg_reload_value;
      end
   endtask

   // Offers one byte, after a random gap when sender idling is on, and waits until the block takes it.
   task automatic send_byte(input logic [7:0] data, input logic last);
      int gap;
      gap = sender_idle_on ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
      fold_accepted_byte(data, last);
   endtask

   // Sends random message bytes followed by their own CRC, so the residue is zero
   // whenever the final xor is zero.
   task automatic send_sealed_packet(input int msg_len);
      logic [15:0] crc;
      logic [7:0]  b;
      crc = crc_running;
      for (int i = 0; i < msg_len; i++) begin
         b = 8'($urandom);
         crc = crc_fold_byte(crc, b);
         send_byte(b, 1'b0);
      end
      send_byte(crc[15:8], 1'b0);
      send_byte(crc[7:0], 1'b1);
   endtask

   // Stops offering bytes and waits until every result has arrived and the
   // pipeline has had time to fold any byte still in flight.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes the initial remainder register first and then the final xor register. The index port is one bit
   // wide, so every index it can carry names a register.
   task automatic load_registers(input logic [15:0] init_value, input logic [15:0] xor_value);
      csr_write_enable <= 1'b1;
      csr_index <= CsrInitialRemainder;
      csr_write_data <= init_value;
      @(posedge clock);
      cfg_reload_value = init_value;
      csr_index <= CsrFinalXor;
      csr_write_data <= xor_value;
      @(posedge clock);
      cfg_final_xor = xor_value;
      csr_write_enable <= 1'b0;
   endtask

   // One-byte packets at the extremes of the byte, with reset register values.
   task automatic test_single_byte_packets();
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h80, 1'b1);
      send_byte(8'h01, 1'b1);
   endtask

   // Bytes without the last mark only advance the remainder.
   task automatic test_multi_byte_packet();
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hA5, 1'b1);
   endtask

   // A packet that carries its own checksum must report a zero residue.
   task automatic test_sealed_packet();
      send_sealed_packet(2);
   endtask

   // Extreme register values; a new initial remainder applies after the next closing byte.
   task automatic test_register_extremes();
      drain_results();
      load_registers(16'h0000, 16'hFFFF);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      drain_results();
      load_registers(16'hFFFF, 16'h0000);
      send_byte(8'h00, 1'b1);
      send_sealed_packet(1);
   endtask

   // Registers written while a packet is open: the final xor applies to this packet,
   // the initial remainder only to the one after it.
   task automatic test_write_during_packet();
      send_byte(8'h12, 1'b0);
      drain_results();
      load_registers(16'h1D0F, 16'h5A5A);
      send_byte(8'h34, 1'b1);
      send_byte(8'h56, 1'b1);
   endtask

   // The receiver holds off for a long stretch while closing bytes keep coming,
   // so the block fills up and drops req_ready.
   task automatic test_result_backpressure();
      drain_results();
      sender_idle_on = 1'b0;
      rsp_hold_cycles = 80;
      do @(posedge clock); while (!rsp_hold_active);
      for (int i = 0; i < 24; i++) begin
         send_byte(8'($urandom), 1'b1);
      end
      drain_results();
      sender_idle_on = 1'b1;
   endtask

   // Random packets in phases with new register settings and idling modes.
   task automatic test_random_packets();
      int          bytes_sent;
      int          phase_bytes;
      int          len;
      int          split;
      logic [15:0] init_value;
      logic [15:0] xor_value;
      bytes_sent = 0;
      while (bytes_sent < 500) begin
         drain_results();
         case ($urandom_range(0, 3))
            0: init_value = 16'h0000;
            1: init_value = 16'hFFFF;
            default: init_value = 16'($urandom);
         endcase
         case ($urandom_range(0, 5))
            0, 1: xor_value = 16'h0000;
            2: xor_value = 16'hFFFF;
            default: xor_value = 16'($urandom);
         endcase
         load_registers(init_value, xor_value);
         sender_idle_on = ($urandom_range(0, 3) != 0);
         receiver_idle_on = ($urandom_range(0, 3) != 0);
         phase_bytes = 0;
         while (phase_bytes < 50) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
            if (cfg_final_xor == 16'h0000 && len >= 3 && $urandom_range(0, 1) == 1) begin
               send_sealed_packet(len - 2);
            end else begin
               // Now and then the registers change in the middle of the packet.
               split = (len >= 2 && $urandom_range(0, 11) == 0) ? $urandom_range(1, len - 1) : 0;
               for (int i = 0; i < len; i++) begin
                  if (split != 0 && i == split) begin
                     drain_results();
                     load_registers(16'($urandom), 16'($urandom));
                  end
                  send_byte(8'($urandom), i == len - 1);
               end
            end
            phase_bytes += len;
         end
         bytes_sent += phase_bytes;
      end
   endtask

   // Result receiver: random stalls per transaction when receiver idling is on, plus a long hold-off on request.
   initial begin : result_receiver
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_cycles != 0) begin
            rsp_hold_active = 1'b1;
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
            rsp_hold_active = 1'b0;
         end
         stall = receiver_idle_on ? $urandom_range(0, 7) : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid && rsp_hold_cycles == 0);
      end
   end

   // Compares each accepted result with the oldest expectation.
   always @(posedge clock) begin : check_results
      crc_result_type expected;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result: checksum_swapped %h residue_zero %b",
                   rsp_checksum_swapped, rsp_residue_zero);
            error_count++;
         end else begin
            expected = expected_results.pop_front();
            if (rsp_checksum_swapped !== expected.checksum_swapped) begin
               $error("checksum_swapped: expected %h, actual %h",
                      expected.checksum_swapped, rsp_checksum_swapped);
               error_count++;
            end
            if (rsp_residue_zero !== expected.residue_zero) begin
               $error("residue_zero: expected %b, actual %b",
                      expected.residue_zero, rsp_residue_zero);
               error_count++;
            end
         end
      end
   end

   // Test sequence.
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_single_byte_packets();
      test_multi_byte_packet();
      test_sealed_packet();
      test_register_extremes();
      test_write_during_packet();
      test_result_backpressure();
      test_random_packets();
      drain_results();
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #500000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/crc16_pkg.sv
rtl/crc16_core.sv
rtl/crc16_ccitt_packet_checker.sv
sim/crc16_ccitt_packet_checker_test.sv
